[rtl/bhs_pkg.sv]
package bhs_pkg;

	localparam int RASTER_DEPTH     = 262144;
	localparam int RASTER_ADDR_BITS = $clog2(RASTER_DEPTH);
	localparam int GRID_INDEX_BITS  = 10;
	localparam int RAW_ADDR_BITS    = 33;

	localparam logic [RAW_ADDR_BITS-1:0] RASTER_LIMIT = RAW_ADDR_BITS'(RASTER_DEPTH);
	localparam logic [9:0] GRID_MASK = 10'((64'd1 << GRID_INDEX_BITS) - 64'd1);
	localparam logic [26:0] COORD_MAX = 27'h7FF_FFFF;
	localparam logic [15:0] HEIGHT_MAX = 16'hFF00;

	localparam logic [1:0] REG_ROW_STRIDE   = 2'd0;
	localparam logic [1:0] REG_COL_STEP     = 2'd1;
	localparam logic [1:0] REG_ROW_STEP     = 2'd2;
	localparam logic [1:0] REG_GRID_SAMPLES = 2'd3;

	localparam logic [10:0] ROW_STRIDE_RESET   = 11'd1;
	localparam logic [25:0] STEP_RESET         = 26'd65536;
	localparam logic [10:0] GRID_SAMPLES_RESET = 11'd500;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [17:0] pixel_address;
		logic [7:0]  pixel_value;
		logic [9:0]  grid_row;
		logic [9:0]  grid_col;
	} in_item_t;

	typedef struct packed {
		logic [26:0] x_pos;
		logic [26:0] y_pos;
		logic [15:0] height;
		logic [19:0] point_index;
		logic        out_of_range;
	} out_item_t;

	typedef struct packed {
		logic                        we;
		logic [RASTER_ADDR_BITS-1:0] addr;
		logic [7:0]                  wdata;
	} ram_req_t;

	typedef struct packed {
		logic [3:0][7:0] z;
		logic [15:0]     fx;
		logic [15:0]     fy;
	} blend_in_t;

endpackage

[rtl/bilinear_heightmap_sampler.sv]
// a pixel write reaches the raster in the cycle it is accepted; one write per cycle while idle
// a sample holds in_ready low until its result is registered, set by four reads through the
//   single raster port plus address and blend steps
// the result sits in an output register, so the next transaction is taken while it waits
// reset: arst_n clears control and loads the register defaults; raster contents stay
//   undefined until written, with no clearing pass
module bilinear_heightmap_sampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [25:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  bhs_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bhs_pkg::out_item_t out_data
);
	import bhs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BASE  = 3'd1;
	localparam logic [2:0] S_SUM   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_LAST  = 3'd4;
	localparam logic [2:0] S_BLEND = 3'd5;
	localparam logic [2:0] S_WAIT  = 3'd6;

	logic [10:0] row_stride_q;
	logic [25:0] col_step_q;
	logic [25:0] row_step_q;
	logic [10:0] grid_samples_q;

	logic [2:0] state_q;
	logic [1:0] rd_cnt_q;

	logic [35:0] x_q;
	logic [35:0] y_q;
	logic [9:0]  col_q;
	logic [20:0] pidx_prod_q;
	logic [19:0] pidx_q;
	logic        idx_flag_q;
	logic        rd_flag_q;
	logic [30:0] base_q;
	logic [RAW_ADDR_BITS-1:0] a11_q;
	logic [2:0][7:0] z_q;

	logic       rd_v_s1;
	logic [1:0] rd_k_s1;
	logic       rd_oob_s1;

	logic       out_valid_q;
	out_item_t  out_q;

	logic        accept;
	logic        wr_go;
	logic [9:0]  row_m;
	logic [9:0]  col_m;
	logic [10:0] n_rows;
	logic [35:0] x_full;
	logic [35:0] y_full;
	logic [20:0] pidx_full;
	logic [30:0] base_full;
	logic [21:0] pidx_sum;
	logic [11:0] rd_off;
	logic [RAW_ADDR_BITS-1:0] rd_addr;
	logic        rd_oob;
	logic [7:0]  rdata;
	logic [7:0]  zval;
	logic        x_sat;
	logic        y_sat;
	logic        out_free;
	logic [15:0] height;
	ram_req_t    ram_req;
	blend_in_t   blend_req;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_go    = accept && (in_data.opcode == OP_WRITE)
		&& ({15'd0, in_data.pixel_address} < RASTER_LIMIT);

	assign row_m     = in_data.grid_row & GRID_MASK;
	assign col_m     = in_data.grid_col & GRID_MASK;
	assign n_rows    = (grid_samples_q >= 11'd1) ? grid_samples_q - 11'd1 : 11'd0;
	assign x_full    = col_m * col_step_q;
	assign y_full    = row_m * row_step_q;
	assign pidx_full = row_m * n_rows;
	assign base_full = row_stride_q * y_q[35:16];
	assign pidx_sum  = {1'b0, pidx_prod_q} + {12'd0, col_q};

	assign rd_off  = (rd_cnt_q[1] ? {1'b0, row_stride_q} : 12'd0) + {11'd0, rd_cnt_q[0]};
	assign rd_addr = a11_q + {21'd0, rd_off};
	assign rd_oob  = (rd_addr >= RASTER_LIMIT);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q   <= ROW_STRIDE_RESET;
			col_step_q     <= STEP_RESET;
			row_step_q     <= STEP_RESET;
			grid_samples_q <= GRID_SAMPLES_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROW_STRIDE:   row_stride_q   <= cfg_wdata[10:0];
				REG_COL_STEP:     col_step_q     <= cfg_wdata;
				REG_ROW_STEP:     row_step_q     <= cfg_wdata;
				REG_GRID_SAMPLES: grid_samples_q <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= 2'd0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_READ);
			if ((state_q == S_WAIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (in_data.opcode == OP_SAMPLE)) begin
						state_q <= S_BASE;
					end
				end
				S_BASE: state_q <= S_SUM;
				S_SUM: begin
					rd_cnt_q <= 2'd0;
					state_q  <= S_READ;
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3) begin
						state_q <= S_LAST;
					end
				end
				S_LAST:  state_q <= S_BLEND;
				S_BLEND: state_q <= S_WAIT;
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_flag_q <= 1'b0;
		end else if (accept) begin
			rd_flag_q <= 1'b0;
		end else if (rd_v_s1 && rd_oob_s1) begin
			rd_flag_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q         <= x_full;
			y_q         <= y_full;
			col_q       <= col_m;
			pidx_prod_q <= pidx_full;
			idx_flag_q  <= ({1'b0, row_m} >= n_rows) || ({1'b0, col_m} >= n_rows);
		end
		if (state_q == S_BASE) begin
			base_q <= base_full;
			pidx_q <= pidx_sum[19:0];
		end
		if (state_q == S_SUM) begin
			a11_q <= {13'd0, x_q[35:16]} + {2'd0, base_q};
		end
		rd_k_s1   <= rd_cnt_q;
		rd_oob_s1 <= rd_oob;
		if (rd_v_s1 && (rd_k_s1 != 2'd3)) begin
			z_q[rd_k_s1] <= zval;
		end
	end

	always_comb begin
		ram_req.we    = wr_go;
		ram_req.wdata = in_data.pixel_value;
		ram_req.addr  = wr_go ? RASTER_ADDR_BITS'(in_data.pixel_address)
			: RASTER_ADDR_BITS'(rd_addr);
	end

	bhs_raster u_raster (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	assign zval = rd_oob_s1 ? 8'd0 : rdata;

	always_comb begin
		blend_req.z  = {zval, z_q[2], z_q[1], z_q[0]};
		blend_req.fx = x_q[15:0];
		blend_req.fy = y_q[15:0];
	end

	bhs_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LAST),
		.req    (blend_req),
		.height (height)
	);

	// output register
	assign x_sat    = (x_q > {9'd0, COORD_MAX});
	assign y_sat    = (y_q > {9'd0, COORD_MAX});
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if ((state_q == S_WAIT) && out_free) begin
			out_q.x_pos        <= x_sat ? COORD_MAX : x_q[26:0];
			out_q.y_pos        <= y_sat ? COORD_MAX : y_q[26:0];
			out_q.height       <= height;
			out_q.point_index  <= pidx_q;
			out_q.out_of_range <= idx_flag_q || rd_flag_q || x_sat || y_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/bhs_raster.sv]
module bhs_raster (
	input  logic              clk,
	input  bhs_pkg::ram_req_t req,
	output logic [7:0]        rdata
);
	import bhs_pkg::*;

	logic [7:0] mem_q [RASTER_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end else begin
			rdata_q <= mem_q[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bhs_interp.sv]
module bhs_interp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bhs_pkg::blend_in_t req,
	output logic [15:0]        height
);
	import bhs_pkg::*;

	logic        v_s1;
	logic [23:0] zw1_s1;
	logic [23:0] zw2_s1;
	logic [15:0] fy_s1;
	logic [15:0] height_s2;

	logic signed [24:0] d2;
	logic signed [41:0] p2;
	logic signed [42:0] s2;

	// a*(1-f) + b*f folded into a*65536 + (b-a)*f
	function automatic logic [23:0] blend_row(logic [7:0] a, logic [7:0] b, logic [15:0] f);
		logic signed [8:0]  d;
		logic signed [25:0] p;
		logic signed [26:0] s;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, f});
		s = $signed({3'b000, a, 16'h0000}) + 27'(p);
		return s[23:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zw1_s1 <= blend_row(req.z[0], req.z[1], req.fx);
			zw2_s1 <= blend_row(req.z[2], req.z[3], req.fx);
			fy_s1  <= req.fy;
		end
	end

	assign d2 = $signed({1'b0, zw2_s1}) - $signed({1'b0, zw1_s1});
	assign p2 = d2 * $signed({1'b0, fy_s1});
	assign s2 = $signed({3'b000, zw1_s1, 16'h0000}) + 43'sd8388608 + 43'(p2);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			height_s2 <= s2[39:24];
		end
	end

	assign height = height_s2;

endmodule

[rtl/bhs_checker.sv]
module bhs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input bhs_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input bhs_pkg::out_item_t out_data
);
	import bhs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.opcode == OP_SAMPLE) |=> !in_ready)
		else $error("new transaction taken during a sample");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.opcode == OP_WRITE) && !out_valid |=> !out_valid)
		else $error("pixel write produced a result");

	a_height_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.height <= HEIGHT_MAX))
		else $error("height above full scale");

endmodule

bind bilinear_heightmap_sampler bhs_checker u_bhs_checker (.*);

[sim/bilinear_heightmap_sampler_tb.sv]
`timescale 1ns / 100ps

module bilinear_heightmap_sampler_tb;

	import bhs_pkg::*;

	localparam int LATENCY      = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1250;

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [25:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	bilinear_heightmap_sampler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	logic [10:0] cfg_row_stride   = ROW_STRIDE_RESET;
	logic [25:0] cfg_col_step     = STEP_RESET;
	logic [25:0] cfg_row_step     = STEP_RESET;
	logic [10:0] cfg_grid_samples = GRID_SAMPLES_RESET;

	logic [7:0] raster_shadow  [RASTER_DEPTH];
	bit         raster_written [RASTER_DEPTH];

	out_item_t expected_points [$];

	int failures   = 0;
	int items_sent = 0;
	int burst_left = 0;
	int ready_mode = 0;
	int ready_hold = 0;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_hold = $urandom_range(32, 200);
		end
		ready_hold--;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic logic [63:0] tap_address(input logic [9:0] row, input logic [9:0] col,
			input int k);
		logic [63:0] x, y, a;
		x = 64'(col & GRID_MASK) * cfg_col_step;
		y = 64'(row & GRID_MASK) * cfg_row_step;
		a = (x >> 16) + 64'(cfg_row_stride) * (y >> 16);
		if (k[0])
			a = a + 1;
		if (k[1])
			a = a + 64'(cfg_row_stride);
		return a;
	endfunction

	function automatic logic [63:0] mix(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] f);
		return a * (64'd65536 - f) + b * f;
	endfunction

	function automatic out_item_t predict_point(input in_item_t item);
		logic [63:0] row, col, n, x, y, fx, fy, a, zw1, zw2, z;
		logic [63:0] tap [4];
		logic flag;
		out_item_t res;
		row = 64'(item.grid_row & GRID_MASK);
		col = 64'(item.grid_col & GRID_MASK);
		n = (cfg_grid_samples >= 1) ? 64'(cfg_grid_samples) - 64'd1 : 64'd0;
		flag = (row >= n) || (col >= n);
		x = col * cfg_col_step;
		y = row * cfg_row_step;
		fx = x & 64'hFFFF;
		fy = y & 64'hFFFF;
		for (int k = 0; k < 4; k++) begin
			a = tap_address(item.grid_row, item.grid_col, k);
			if (a >= RASTER_DEPTH) begin
				flag = 1'b1;
				tap[k] = 64'd0;
			end else begin
				tap[k] = 64'(raster_shadow[a[17:0]]);
			end
		end
		zw1 = mix(tap[0], tap[1], fx);
		zw2 = mix(tap[2], tap[3], fx);
		z = (mix(zw1, zw2, fy) + (64'd1 << 23)) >> 24;
		// saturate after addressing, fractions keep the raw product
		if (x > COORD_MAX) begin
			x = 64'(COORD_MAX);
			flag = 1'b1;
		end
		if (y > COORD_MAX) begin
			y = 64'(COORD_MAX);
			flag = 1'b1;
		end
		res.x_pos = x[26:0];
		res.y_pos = y[26:0];
		res.height = z[15:0];
		res.point_index = 20'(row * n + col);
		res.out_of_range = flag;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual %p", $time, out_data);
				failures++;
			end else begin
				want = expected_points.pop_front();
				compare_field("x_pos", 32'(want.x_pos), 32'(out_data.x_pos));
				compare_field("y_pos", 32'(want.y_pos), 32'(out_data.y_pos));
				compare_field("height", 32'(want.height), 32'(out_data.height));
				compare_field("point_index", 32'(want.point_index), 32'(out_data.point_index));
				compare_field("out_of_range", 32'(want.out_of_range), 32'(out_data.out_of_range));
			end
		end
	end

	task automatic send_item(input in_item_t item);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_data <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (item.opcode == OP_WRITE) begin
			raster_shadow[item.pixel_address] = item.pixel_value;
			raster_written[item.pixel_address] = 1'b1;
		end else begin
			expected_points.push_back(predict_point(item));
		end
		items_sent++;
	endtask

	function automatic in_item_t random_item(input logic op);
		in_item_t item;
		item.opcode = op;
		item.pixel_address = 18'($urandom);
		item.pixel_value = 8'($urandom);
		item.grid_row = 10'($urandom);
		item.grid_col = 10'($urandom);
		return item;
	endfunction

	task automatic write_pixel(input logic [17:0] addr, input logic [7:0] value);
		in_item_t item;
		item = random_item(OP_WRITE);
		item.pixel_address = addr;
		item.pixel_value = value;
		send_item(item);
	endtask

	// fill any unwritten in-raster tap first, then request the sample
	task automatic sample_at(input logic [9:0] row, input logic [9:0] col);
		logic [63:0] a;
		in_item_t item;
		for (int k = 0; k < 4; k++) begin
			a = tap_address(row, col, k);
			if (a < RASTER_DEPTH && !raster_written[a[17:0]])
				write_pixel(a[17:0], 8'($urandom));
		end
		item = random_item(OP_SAMPLE);
		item.grid_row = row;
		item.grid_col = col;
		send_item(item);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_config(input logic [10:0] stride, input logic [25:0] cstep,
			input logic [25:0] rstep, input logic [10:0] grid);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ROW_STRIDE;
		cfg_wdata <= {15'($urandom), stride};
		@(negedge clk);
		cfg_index <= REG_COL_STEP;
		cfg_wdata <= cstep;
		@(negedge clk);
		cfg_index <= REG_ROW_STEP;
		cfg_wdata <= rstep;
		@(negedge clk);
		cfg_index <= REG_GRID_SAMPLES;
		cfg_wdata <= {15'($urandom), grid};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_row_stride = stride;
		cfg_col_step = cstep;
		cfg_row_step = rstep;
		cfg_grid_samples = grid;
	endtask

	function automatic logic [25:0] pick_step();
		case ($urandom_range(0, 3))
			0, 1: return 26'($urandom_range(0, 1 << 17));
			2: return 26'($urandom_range(0, 1 << 20));
			default: return 26'($urandom);
		endcase
	endfunction

	task automatic random_config();
		logic [10:0] stride, grid;
		stride = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1025));
		if ($urandom_range(0, 9) == 0)
			grid = 11'($urandom);
		else if ($urandom_range(0, 1) == 0)
			grid = 11'($urandom_range(2, 64));
		else
			grid = 11'($urandom_range(2, 1025));
		load_config(stride, pick_step(), pick_step(), grid);
	endtask

	task automatic test_reset_defaults();
		write_pixel(18'd0, 8'd0);
		write_pixel(18'd1, 8'd255);
		write_pixel(18'd2, 8'd128);
		sample_at(10'd0, 10'd0);
		sample_at(10'd0, 10'd1);
		// row past the grid, still computed
		sample_at(10'd499, 10'd0);
	endtask

	task automatic test_pixel_extremes();
		write_pixel(18'h3FFFF, 8'hFF);
		write_pixel(18'h00000, 8'h00);
	endtask

	task automatic test_raster_edge();
		load_config(11'd1025, 26'h10000, 26'h10000, 11'd1025);
		// top taps at the last two pixels, bottom taps past the raster
		sample_at(10'd255, 10'd767);
	endtask

	task automatic test_coordinate_overflow();
		load_config(11'd1, 26'h3FFFFFF, 26'd0, 11'd1025);
		sample_at(10'd0, 10'd1023);
		sample_at(10'd0, 10'd1);
		load_config(11'd1, 26'd0, 26'h3FFFFFF, 11'd1025);
		sample_at(10'd1023, 10'd0);
		sample_at(10'd2, 10'd0);
	endtask

	task automatic test_tiny_grid();
		load_config(ROW_STRIDE_RESET, STEP_RESET, STEP_RESET, 11'd0);
		sample_at(10'd0, 10'd0);
		load_config(ROW_STRIDE_RESET, STEP_RESET, STEP_RESET, 11'd1);
		sample_at(10'd0, 10'd0);
		load_config(ROW_STRIDE_RESET, STEP_RESET, STEP_RESET, 11'd2);
		sample_at(10'd0, 10'd0);
		sample_at(10'd1, 10'd0);
	endtask

	task automatic test_index_wrap();
		load_config(11'd2047, 26'd0, 26'd0, 11'd2047);
		sample_at(10'd1023, 10'd1023);
	endtask

	task automatic test_random_traffic();
		int start, pick, n;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			random_config();
			n = (cfg_grid_samples >= 2) ? int'(cfg_grid_samples) - 1 : 0;
			if (n > 1024)
				n = 1024;
			repeat ($urandom_range(80, 200)) begin
				if (items_sent - start >= RANDOM_ITEMS)
					break;
				pick = $urandom_range(0, 99);
				if (pick < 70 && n > 0)
					sample_at(10'($urandom_range(0, n - 1)), 10'($urandom_range(0, n - 1)));
				else if (pick < 82)
					sample_at(10'($urandom), 10'($urandom));
				else
					write_pixel(18'($urandom), 8'($urandom));
				if ($urandom_range(0, 199) == 0)
					wait_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ROW_STRIDE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_pixel_extremes();
		test_raster_edge();
		test_coordinate_overflow();
		test_tiny_grid();
		test_index_wrap();
		test_random_traffic();

		wait_drained();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
